/* design/hga_pkg.sv */
`timescale 1ns / 1ps

package hga_pkg;

   // grid geometry and cell format
   localparam int GRID_W     = 256;
   localparam int GRID_H     = 256;
   localparam int COUNT_BITS = 16;
   localparam int COMPONENTS = 8;

   localparam int X_BITS    = $clog2(GRID_W);
   localparam int Y_BITS    = $clog2(GRID_H);
   localparam int COMP_BITS = $clog2(COMPONENTS);
   localparam int CELL_AW   = X_BITS + Y_BITS;
   localparam int CELLS     = GRID_W * GRID_H;
   localparam int LIST_AW   = $clog2(CELLS);
   localparam int TC_BITS   = $clog2(CELLS + 1);

   // configuration register indexes
   localparam logic REG_GRID_WIDTH  = 1'b0;
   localparam logic REG_GRID_HEIGHT = 1'b1;

   // request operation codes
   localparam logic [1:0] FUNC_ADD   = 2'd0;
   localparam logic [1:0] FUNC_READ  = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;

   typedef struct packed {
      logic [COUNT_BITS-1:0] count;
      logic [31:0]           color;
      logic [COMP_BITS-1:0]  comp;
   } cell_type;

   typedef struct packed {
      logic [Y_BITS-1:0] y;
      logic [X_BITS-1:0] x;
   } point_type;

   // per-channel floor average of two packed colors
   function automatic logic [31:0] color_avg(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] r;
      logic [8:0]  s;
      r = '0;
      for (int i = 0; i < 4; i++) begin
         s = {1'b0, a[8*i +: 8]} + {1'b0, b[8*i +: 8]};
         r[8*i +: 8] = s[8:1];
      end
      return r;
   endfunction

endpackage

/* design/hit_grid_accumulator_top.sv */
`timescale 1ns / 1ps

// Hit grid accumulator: a 2D hit histogram with a list of first-touched cells.
// Request channel (req_*, valid/ready) carries one operation per transaction:
// add a hit, read back an entry of the touched list, or clear everything.
// Each request produces exactly one response on the rsp_* channel (valid/ready).
// Configuration: csr_write with csr_index/csr_wdata sets grid width and height;
// write only while idle.
// Timing: after acceptance an in-bounds add passes through ST_ADD, a list read
// of a valid index through ST_LIST (list memory read) and ST_READ (cell memory
// read), and every other request through ST_FIN, before the response
// registers; the next request is taken once the sequencer is back in ST_IDLE.
// One request is in flight at a time, set by the read-modify-write through the
// cell memory with its registered read.
// A clear answers through ST_FIN while it sweeps the cell memory one entry per
// cycle over all 2**(X_BITS+Y_BITS) = 65536 entries, with req_ready low.
// Reset runs the same sweep before the first request is taken;
// width and height return to 256.
// When the receiver stalls, the finished response holds in the output register
// and the next request is still taken; its result waits in place until the
// output register frees up.
module hit_grid_accumulator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_hit_x,
   input  logic [31:0] req_hit_y,
   input  logic [2:0]  req_component,
   input  logic [31:0] req_hit_color,
   input  logic [15:0] req_read_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_in_bounds,
   output logic [15:0] rsp_cell_count,
   output logic [15:0] rsp_max_count,
   output logic [31:0] rsp_cell_color,
   output logic [2:0]  rsp_cell_component,
   output logic [7:0]  rsp_point_x,
   output logic [7:0]  rsp_point_y,
   output logic [16:0] rsp_list_length,
   output logic        rsp_index_valid,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [8:0]  csr_wdata
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_ADD  = 3'd1;
   localparam logic [2:0] ST_LIST = 3'd2;
   localparam logic [2:0] ST_READ = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;

   localparam int XW = hga_pkg::X_BITS;
   localparam int YW = hga_pkg::Y_BITS;
   localparam int CB = hga_pkg::COUNT_BITS;
   localparam int TW = hga_pkg::TC_BITS;

   // memories
   hga_pkg::cell_type  cell_mem [2**hga_pkg::CELL_AW];
   hga_pkg::point_type list_mem [hga_pkg::CELLS];

   hga_pkg::cell_type  cell_rd_ff;
   hga_pkg::point_type list_rd_ff;

   // control state
   logic [2:0]                 state_ff, state_in;
   logic                       clr_busy_ff, clr_busy_in;
   logic [hga_pkg::CELL_AW-1:0] clr_addr_ff, clr_addr_in;
   logic [8:0]                 width_ff, height_ff;
   logic [TW-1:0]              tc_ff, tc_in;
   logic [CB-1:0]              high_ff, high_in;

   // captured request
   logic [XW-1:0]                px_ff, px_in;
   logic [YW-1:0]                py_ff, py_in;
   logic [hga_pkg::COMP_BITS-1:0] comp_ff, comp_in;
   logic [31:0]                  color_ff, color_in;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        inb_ff, inb_in;
   logic [15:0] cnt_ff, cnt_in;
   logic [15:0] max_ff, max_in;
   logic [31:0] ccol_ff, ccol_in;
   logic [2:0]  ccomp_ff, ccomp_in;
   logic [7:0]  ox_ff, ox_in;
   logic [7:0]  oy_ff, oy_in;
   logic [16:0] len_ff, len_in;
   logic        ivld_ff, ivld_in;

   // memory port controls
   logic                        cell_we, cell_re;
   logic [hga_pkg::CELL_AW-1:0] cell_waddr, cell_raddr;
   hga_pkg::cell_type           cell_wdata;
   logic                        list_we, list_re;
   logic [hga_pkg::LIST_AW-1:0] list_waddr, list_raddr;

   logic              accept, out_free;
   logic [30:0]       w_lim, h_lim;
   logic              hit_ok, idx_ok;
   hga_pkg::cell_type new_cell;
   logic              first_hit;

   assign req_ready = (state_ff == ST_IDLE) && !clr_busy_ff;
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // bounds check against the effective grid size
   assign w_lim  = (31'(width_ff) < 31'(hga_pkg::GRID_W)) ? 31'(width_ff)
                                                         : 31'(hga_pkg::GRID_W);
   assign h_lim  = (31'(height_ff) < 31'(hga_pkg::GRID_H)) ? 31'(height_ff)
                                                          : 31'(hga_pkg::GRID_H);
   assign hit_ok = (req_hit_x[30:0] < w_lim) && (req_hit_y[30:0] < h_lim);
   assign idx_ok = TW'(req_read_index) < tc_ff;

   // cell update from the registered read data
   always_comb begin
      new_cell.comp  = comp_ff;
      new_cell.color = hga_pkg::color_avg(cell_rd_ff.color, color_ff);
      new_cell.count = (&cell_rd_ff.count) ? cell_rd_ff.count
                                           : cell_rd_ff.count + CB'(1);
   end
   assign first_hit = (cell_rd_ff.count == '0) && (tc_ff < TW'(hga_pkg::CELLS));

   // sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      clr_busy_in  = clr_busy_ff;
      clr_addr_in  = clr_addr_ff;
      tc_in        = tc_ff;
      high_in      = high_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      comp_in      = comp_ff;
      color_in     = color_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      inb_in       = inb_ff;
      cnt_in       = cnt_ff;
      max_in       = max_ff;
      ccol_in      = ccol_ff;
      ccomp_in     = ccomp_ff;
      ox_in        = ox_ff;
      oy_in        = oy_ff;
      len_in       = len_ff;
      ivld_in      = ivld_ff;
      cell_we      = 1'b0;
      cell_waddr   = clr_addr_ff;
      cell_wdata   = '0;
      cell_re      = 1'b0;
      cell_raddr   = {req_hit_y[YW-1:0], req_hit_x[XW-1:0]};
      list_we      = 1'b0;
      list_waddr   = tc_ff[hga_pkg::LIST_AW-1:0];
      list_re      = 1'b0;
      list_raddr   = hga_pkg::LIST_AW'(req_read_index);

      // clearing sweep over the cell memory
      if (clr_busy_ff) begin
         cell_we     = 1'b1;
         clr_addr_in = clr_addr_ff + hga_pkg::CELL_AW'(1);
         if (&clr_addr_ff) begin
            clr_busy_in = 1'b0;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               px_in    = req_hit_x[XW-1:0];
               py_in    = req_hit_y[YW-1:0];
               comp_in  = req_component[hga_pkg::COMP_BITS-1:0];
               color_in = req_hit_color;
               state_in = ST_FIN;
               unique case (req_func)
                  hga_pkg::FUNC_ADD: begin
                     if (hit_ok) begin
                        cell_re  = 1'b1;
                        state_in = ST_ADD;
                     end
                  end
                  hga_pkg::FUNC_READ: begin
                     if (idx_ok) begin
                        list_re  = 1'b1;
                        state_in = ST_LIST;
                     end
                  end
                  hga_pkg::FUNC_CLEAR: begin
                     tc_in       = '0;
                     high_in     = '0;
                     clr_busy_in = 1'b1;
                     clr_addr_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_ADD: begin
            if (out_free) begin
               cell_we    = 1'b1;
               cell_waddr = {py_ff, px_ff};
               cell_wdata = new_cell;
               if (new_cell.count > high_ff) begin
                  high_in = new_cell.count;
               end
               if (first_hit) begin
                  list_we = 1'b1;
                  tc_in   = tc_ff + TW'(1);
               end
               rsp_valid_in = 1'b1;
               inb_in       = 1'b1;
               cnt_in       = 16'(new_cell.count);
               max_in       = 16'(high_in);
               ccol_in      = new_cell.color;
               ccomp_in     = 3'(new_cell.comp);
               ox_in        = 8'(px_ff);
               oy_in        = 8'(py_ff);
               len_in       = 17'(tc_in);
               ivld_in      = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         ST_LIST: begin
            cell_re    = 1'b1;
            cell_raddr = {list_rd_ff.y, list_rd_ff.x};
            px_in      = list_rd_ff.x;
            py_in      = list_rd_ff.y;
            state_in   = ST_READ;
         end
         ST_READ: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               inb_in       = 1'b0;
               cnt_in       = 16'(cell_rd_ff.count);
               max_in       = 16'(high_ff);
               ccol_in      = cell_rd_ff.color;
               ccomp_in     = 3'(cell_rd_ff.comp);
               ox_in        = 8'(px_ff);
               oy_in        = 8'(py_ff);
               len_in       = 17'(tc_ff);
               ivld_in      = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               inb_in       = 1'b0;
               cnt_in       = '0;
               max_in       = 16'(high_ff);
               ccol_in      = '0;
               ccomp_in     = '0;
               ox_in        = '0;
               oy_in        = '0;
               len_in       = 17'(tc_ff);
               ivld_in      = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // cell memory, registered read
   always_ff @(posedge clock) begin
      if (cell_we) begin
         cell_mem[cell_waddr] <= cell_wdata;
      end
      if (cell_re) begin
         cell_rd_ff <= cell_mem[cell_raddr];
      end
   end

   // touched list memory, registered read
   always_ff @(posedge clock) begin
      if (list_we) begin
         list_mem[list_waddr] <= '{y: py_ff, x: px_ff};
      end
      if (list_re) begin
         list_rd_ff <= list_mem[list_raddr];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         width_ff     <= 9'd256;
         height_ff    <= 9'd256;
         tc_ff        <= '0;
         high_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_busy_ff  <= clr_busy_in;
         clr_addr_ff  <= clr_addr_in;
         tc_ff        <= tc_in;
         high_ff      <= high_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            unique case (csr_index)
               hga_pkg::REG_GRID_WIDTH:  width_ff  <= csr_wdata;
               hga_pkg::REG_GRID_HEIGHT: height_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      px_ff    <= px_in;
      py_ff    <= py_in;
      comp_ff  <= comp_in;
      color_ff <= color_in;
      inb_ff   <= inb_in;
      cnt_ff   <= cnt_in;
      max_ff   <= max_in;
      ccol_ff  <= ccol_in;
      ccomp_ff <= ccomp_in;
      ox_ff    <= ox_in;
      oy_ff    <= oy_in;
      len_ff   <= len_in;
      ivld_ff  <= ivld_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_in_bounds      = inb_ff;
   assign rsp_cell_count     = cnt_ff;
   assign rsp_max_count      = max_ff;
   assign rsp_cell_color     = ccol_ff;
   assign rsp_cell_component = ccomp_ff;
   assign rsp_point_x        = ox_ff;
   assign rsp_point_y        = oy_ff;
   assign rsp_list_length    = len_ff;
   assign rsp_index_valid    = ivld_ff;

endmodule

/* design/hga_checker.sv */
`timescale 1ns / 1ps

module hga_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_in_bounds,
   input logic [15:0] rsp_cell_count,
   input logic [15:0] rsp_max_count,
   input logic [16:0] rsp_list_length,
   input logic        rsp_index_valid
);

   // no response survives a reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cell_count)
         && $stable(rsp_max_count) && $stable(rsp_list_length))
      else $error("stalled response changed");

   // a counted hit leaves a nonzero count no larger than the maximum
   a_hit_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_in_bounds |->
         rsp_cell_count != 16'd0 && rsp_max_count >= rsp_cell_count
         && rsp_list_length != 17'd0)
      else $error("counted hit with inconsistent count");

   // a list read and a counted hit never share a transaction
   a_kind_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_in_bounds && rsp_index_valid))
      else $error("response flags both a hit and a list read");

   // a valid list read implies a nonempty list
   a_read_list: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_index_valid |-> rsp_list_length != 17'd0)
      else $error("list read valid on an empty list");

endmodule

bind hit_grid_accumulator_top hga_checker u_hga_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_in_bounds   (rsp_in_bounds),
   .rsp_cell_count  (rsp_cell_count),
   .rsp_max_count   (rsp_max_count),
   .rsp_list_length (rsp_list_length),
   .rsp_index_valid (rsp_index_valid)
);

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned CYCLE_LIMIT = 4_000_000;
   localparam int unsigned HAMMER_HITS = 200;
   localparam int unsigned PHASE_ITEMS = 260;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] hit_x;
      logic [31:0] hit_y;
      logic [2:0]  component;
      logic [31:0] hit_color;
      logic [15:0] read_index;
   } hit_request_type;

   typedef struct packed {
      logic        in_bounds;
      logic [15:0] cell_count;
      logic [15:0] max_count;
      logic [31:0] cell_color;
      logic [2:0]  cell_component;
      logic [7:0]  point_x;
      logic [7:0]  point_y;
      logic [16:0] list_length;
      logic        index_valid;
   } cell_report_type;

   typedef enum logic [1:0] {ROW_CSR, ROW_OPEN, ROW_KNOWN} row_kind_type;

   typedef struct packed {
      row_kind_type    kind;
      logic [8:0]      width_val;
      logic [8:0]      height_val;
      hit_request_type op;
      cell_report_type answer;
   } plan_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_func = '0;
   logic [31:0] req_hit_x = '0;
   logic [31:0] req_hit_y = '0;
   logic [2:0]  req_component = '0;
   logic [31:0] req_hit_color = '0;
   logic [15:0] req_read_index = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_in_bounds;
   logic [15:0] rsp_cell_count;
   logic [15:0] rsp_max_count;
   logic [31:0] rsp_cell_color;
   logic [2:0]  rsp_cell_component;
   logic [7:0]  rsp_point_x;
   logic [7:0]  rsp_point_y;
   logic [16:0] rsp_list_length;
   logic        rsp_index_valid;
   logic        csr_write = 1'b0;
   logic        csr_index = 1'b0;
   logic [8:0]  csr_wdata = '0;

   // shadow copy of the grid, the touched list and the registers
   logic [hga_pkg::COUNT_BITS-1:0] shadow_count [hga_pkg::CELLS];
   logic [31:0]                    shadow_color [hga_pkg::CELLS];
   logic [hga_pkg::COMP_BITS-1:0]  shadow_comp [hga_pkg::CELLS];
   logic [hga_pkg::X_BITS-1:0]     shadow_list_x [hga_pkg::CELLS];
   logic [hga_pkg::Y_BITS-1:0]     shadow_list_y [hga_pkg::CELLS];
   int unsigned                    shadow_list_len;
   logic [hga_pkg::COUNT_BITS-1:0] shadow_peak;
   logic [8:0]                     shadow_width;
   logic [8:0]                     shadow_height;

   cell_report_type owed_cell_reports [$];
   plan_row_type    directed_plan [$];
   int unsigned     mismatch_count = 0;
   int unsigned     report_count = 0;
   int unsigned     cycle_count = 0;
   bit              quiet = 1'b0;

   hit_grid_accumulator_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_hit_x          (req_hit_x),
      .req_hit_y          (req_hit_y),
      .req_component      (req_component),
      .req_hit_color      (req_hit_color),
      .req_read_index     (req_read_index),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_in_bounds      (rsp_in_bounds),
      .rsp_cell_count     (rsp_cell_count),
      .rsp_max_count      (rsp_max_count),
      .rsp_cell_color     (rsp_cell_color),
      .rsp_cell_component (rsp_cell_component),
      .rsp_point_x        (rsp_point_x),
      .rsp_point_y        (rsp_point_y),
      .rsp_list_length    (rsp_list_length),
      .rsp_index_valid    (rsp_index_valid),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // clock
   initial begin
      forever #2 clock = ~clock;
   end

   // columns or rows actually in use for a register value
   function automatic int unsigned span_in_use(input logic [8:0] reg_val,
                                               input int unsigned limit);
      return (reg_val < limit) ? reg_val : limit;
   endfunction

   // per-channel floor average of two packed colors
   function automatic logic [31:0] mix_colors(input logic [31:0] old_c,
                                              input logic [31:0] new_c);
      logic [31:0] mixed;
      for (int ch = 0; ch < 32; ch += 8)
         mixed[ch +: 8] = 8'((9'(old_c[ch +: 8]) + 9'(new_c[ch +: 8])) >> 1);
      return mixed;
   endfunction

   function automatic void wipe_shadow();
      foreach (shadow_count[i]) begin
         shadow_count[i] = '0;
         shadow_color[i] = '0;
         shadow_comp[i] = '0;
      end
      shadow_list_len = 0;
      shadow_peak = '0;
   endfunction

   function automatic cell_report_type with_cell(input cell_report_type rep,
                                                 input int unsigned cell_idx,
                                                 input int unsigned x,
                                                 input int unsigned y);
      rep.cell_count = 16'(shadow_count[cell_idx]);
      rep.cell_color = shadow_color[cell_idx];
      rep.cell_component = 3'(shadow_comp[cell_idx]);
      rep.point_x = 8'(x);
      rep.point_y = 8'(y);
      return rep;
   endfunction

   // apply one transaction to the shadow grid and return what the block reports
   function automatic cell_report_type apply_grid_op(input hit_request_type op);
      cell_report_type rep;
      logic [30:0]     ux;
      logic [30:0]     uy;
      int unsigned     cell_idx;
      int unsigned     px;
      int unsigned     py;
      rep = '0;
      unique case (op.func)
         hga_pkg::FUNC_ADD: begin
            ux = op.hit_x[30:0];
            uy = op.hit_y[30:0];
            if (ux < span_in_use(shadow_width, hga_pkg::GRID_W) &&
                uy < span_in_use(shadow_height, hga_pkg::GRID_H)) begin
               cell_idx = uy * hga_pkg::GRID_W + ux;
               shadow_comp[cell_idx] = hga_pkg::COMP_BITS'(op.component);
               shadow_color[cell_idx] = mix_colors(shadow_color[cell_idx], op.hit_color);
               if (shadow_count[cell_idx] != '1)
                  shadow_count[cell_idx] = shadow_count[cell_idx] + hga_pkg::COUNT_BITS'(1);
               if (shadow_count[cell_idx] > shadow_peak)
                  shadow_peak = shadow_count[cell_idx];
               // first hit on a cell goes onto the touched list
               if (shadow_count[cell_idx] == 1 && shadow_list_len < hga_pkg::CELLS) begin
                  shadow_list_x[shadow_list_len] = hga_pkg::X_BITS'(ux);
                  shadow_list_y[shadow_list_len] = hga_pkg::Y_BITS'(uy);
                  shadow_list_len++;
               end
               rep.in_bounds = 1'b1;
               rep = with_cell(rep, cell_idx, ux, uy);
            end
         end
         hga_pkg::FUNC_READ: begin
            if (op.read_index < shadow_list_len) begin
               px = shadow_list_x[op.read_index];
               py = shadow_list_y[op.read_index];
               rep = with_cell(rep, py * hga_pkg::GRID_W + px, px, py);
               rep.index_valid = 1'b1;
            end
         end
         hga_pkg::FUNC_CLEAR: wipe_shadow();
         default: ;
      endcase
      rep.max_count = 16'(shadow_peak);
      rep.list_length = 17'(shadow_list_len);
      return rep;
   endfunction

   // random transaction, mostly hits inside the grid and reads of live entries
   function automatic hit_request_type random_request();
      hit_request_type op;
      int unsigned     w_eff;
      int unsigned     h_eff;
      int unsigned     pick;
      w_eff = span_in_use(shadow_width, hga_pkg::GRID_W);
      h_eff = span_in_use(shadow_height, hga_pkg::GRID_H);
      op.hit_x = $urandom;
      op.hit_y = $urandom;
      op.component = 3'($urandom);
      op.hit_color = $urandom;
      op.read_index = 16'($urandom);
      pick = $urandom_range(99);
      if (pick < 72) begin
         op.func = hga_pkg::FUNC_ADD;
         if (w_eff != 0 && h_eff != 0 && $urandom_range(99) < 88) begin
            op.hit_x[30:0] = 31'($urandom_range(w_eff - 1));
            op.hit_y[30:0] = 31'($urandom_range(h_eff - 1));
         end else if ($urandom_range(1) == 1) begin
            // just off the right edge
            op.hit_x[30:0] = 31'(w_eff + $urandom_range(2));
            op.hit_y[30:0] = 31'($urandom_range(h_eff));
         end
      end else if (pick < 96) begin
         op.func = hga_pkg::FUNC_READ;
         if (shadow_list_len != 0 && $urandom_range(99) < 85)
            op.read_index = 16'($urandom_range(shadow_list_len - 1));
         else if ($urandom_range(1) == 1)
            op.read_index = 16'(shadow_list_len);
      end else begin
         op.func = FUNC_UNUSED;
      end
      return op;
   endfunction

   // table row builders
   function automatic plan_row_type op_row(input logic [1:0] f, input logic [31:0] x,
                                           input logic [31:0] y, input logic [2:0] c,
                                           input logic [31:0] col, input logic [15:0] idx);
      plan_row_type row;
      row = '0;
      row.kind = ROW_OPEN;
      row.op = '{f, x, y, c, col, idx};
      return row;
   endfunction

   function automatic plan_row_type known(input plan_row_type row, input logic ib,
                                          input logic [15:0] cnt, input logic [15:0] mx,
                                          input logic [31:0] col, input logic [2:0] cmp,
                                          input logic [7:0] px, input logic [7:0] py,
                                          input logic [16:0] len, input logic iv);
      row.kind = ROW_KNOWN;
      row.answer = '{ib, cnt, mx, col, cmp, px, py, len, iv};
      return row;
   endfunction

   function automatic plan_row_type csr_row(input logic [8:0] w, input logic [8:0] h);
      plan_row_type row;
      row = '0;
      row.kind = ROW_CSR;
      row.width_val = w;
      row.height_val = h;
      return row;
   endfunction

   task automatic flag_mismatch(input string field, input logic [31:0] got,
                                input logic [31:0] want);
      mismatch_count++;
      $display("mismatch in %s at response %0d: got %0h, expected %0h",
               field, report_count, got, want);
   endtask

   task automatic check_cell_report(input cell_report_type got);
      cell_report_type want;
      if (owed_cell_reports.size() == 0) begin
         flag_mismatch("response with nothing outstanding", 32'(got.list_length), 32'd0);
         return;
      end
      want = owed_cell_reports.pop_front();
      if (got.in_bounds !== want.in_bounds)
         flag_mismatch("in_bounds", 32'(got.in_bounds), 32'(want.in_bounds));
      if (got.cell_count !== want.cell_count)
         flag_mismatch("cell_count", 32'(got.cell_count), 32'(want.cell_count));
      if (got.max_count !== want.max_count)
         flag_mismatch("max_count", 32'(got.max_count), 32'(want.max_count));
      if (got.cell_color !== want.cell_color)
         flag_mismatch("cell_color", got.cell_color, want.cell_color);
      if (got.cell_component !== want.cell_component)
         flag_mismatch("cell_component", 32'(got.cell_component),
                       32'(want.cell_component));
      if (got.point_x !== want.point_x)
         flag_mismatch("point_x", 32'(got.point_x), 32'(want.point_x));
      if (got.point_y !== want.point_y)
         flag_mismatch("point_y", 32'(got.point_y), 32'(want.point_y));
      if (got.list_length !== want.list_length)
         flag_mismatch("list_length", 32'(got.list_length), 32'(want.list_length));
      if (got.index_valid !== want.index_valid)
         flag_mismatch("index_valid", 32'(got.index_valid), 32'(want.index_valid));
      report_count++;
   endtask

   // present one transaction, with random gaps ahead of it
   task automatic issue_request(input hit_request_type op, input bit pinned,
                                input cell_report_type pinned_rep);
      cell_report_type rep;
      while (!quiet && $urandom_range(99) < 21) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= op.func;
      req_hit_x <= op.hit_x;
      req_hit_y <= op.hit_y;
      req_component <= op.component;
      req_hit_color <= op.hit_color;
      req_read_index <= op.read_index;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      rep = apply_grid_op(op);
      owed_cell_reports.push_back(pinned ? pinned_rep : rep);
   endtask

   // all responses back and the clearing sweep done
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (owed_cell_reports.size() != 0) @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic configure_grid(input logic [8:0] w, input logic [8:0] h);
      csr_write <= 1'b1;
      csr_index <= hga_pkg::REG_GRID_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      csr_index <= hga_pkg::REG_GRID_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      csr_write <= 1'b0;
      shadow_width = w;
      shadow_height = h;
   endtask

   // response side: random stalls and checking
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         check_cell_report('{rsp_in_bounds, rsp_cell_count, rsp_max_count, rsp_cell_color,
                             rsp_cell_component, rsp_point_x, rsp_point_y,
                             rsp_list_length, rsp_index_valid});
      rsp_ready <= quiet || ($urandom_range(99) >= 21);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("hit_grid_accumulator_top test failed");
         $finish;
      end
   end

   // stimulus
   initial begin
      hit_request_type op;
      int unsigned     sat_x;
      int unsigned     sat_y;

      wipe_shadow();
      shadow_width = 9'd256;
      shadow_height = 9'd256;

      directed_plan = {
         // empty list after reset, unused code
         known(op_row(hga_pkg::FUNC_READ, 0, 0, 0, 0, 16'h0000),
               0, 0, 0, 32'h0, 0, 8'h00, 8'h00, 0, 0),
         known(op_row(FUNC_UNUSED, 32'hffffffff, 32'hffffffff, 7, 32'hffffffff, 16'hffff),
               0, 0, 0, 32'h0, 0, 8'h00, 8'h00, 0, 0),
         // corners, edges and the ignored top bit
         known(op_row(hga_pkg::FUNC_ADD, 0, 0, 7, 32'hffffffff, 16'hffff),
               1, 1, 1, 32'h7f7f7f7f, 7, 8'h00, 8'h00, 1, 0),
         known(op_row(hga_pkg::FUNC_ADD, 255, 255, 0, 32'h80402010, 0),
               1, 1, 1, 32'h40201008, 0, 8'hff, 8'hff, 2, 0),
         known(op_row(hga_pkg::FUNC_ADD, 256, 0, 1, 32'h11111111, 0),
               0, 0, 1, 32'h0, 0, 8'h00, 8'h00, 2, 0),
         known(op_row(hga_pkg::FUNC_ADD, 0, 256, 2, 32'h22222222, 0),
               0, 0, 1, 32'h0, 0, 8'h00, 8'h00, 2, 0),
         known(op_row(hga_pkg::FUNC_ADD, 32'h80000000, 32'h80000005, 3, 32'h12345678, 0),
               1, 1, 1, 32'h091a2b3c, 3, 8'h00, 8'h05, 3, 0),
         known(op_row(hga_pkg::FUNC_ADD, 32'hffffffff, 0, 4, 32'h33333333, 0),
               0, 0, 1, 32'h0, 0, 8'h00, 8'h00, 3, 0),
         known(op_row(hga_pkg::FUNC_ADD, 0, 32'h7fffffff, 4, 32'h44444444, 0),
               0, 0, 1, 32'h0, 0, 8'h00, 8'h00, 3, 0),
         // second hit averages the color
         known(op_row(hga_pkg::FUNC_ADD, 0, 0, 5, 32'h01010101, 0),
               1, 2, 2, 32'h40404040, 5, 8'h00, 8'h00, 3, 0),
         // list reads, inside and past the end
         known(op_row(hga_pkg::FUNC_READ, 0, 0, 0, 0, 16'd0),
               0, 2, 2, 32'h40404040, 5, 8'h00, 8'h00, 3, 1),
         known(op_row(hga_pkg::FUNC_READ, 0, 0, 0, 0, 16'd2),
               0, 1, 2, 32'h091a2b3c, 3, 8'h00, 8'h05, 3, 1),
         known(op_row(hga_pkg::FUNC_READ, 0, 0, 0, 0, 16'd1),
               0, 1, 2, 32'h40201008, 0, 8'hff, 8'hff, 3, 1),
         known(op_row(hga_pkg::FUNC_READ, 0, 0, 0, 0, 16'd3),
               0, 0, 2, 32'h0, 0, 8'h00, 8'h00, 3, 0),
         known(op_row(hga_pkg::FUNC_READ, 0, 0, 0, 0, 16'hffff),
               0, 0, 2, 32'h0, 0, 8'h00, 8'h00, 3, 0),
         // clear wipes everything
         known(op_row(hga_pkg::FUNC_CLEAR, 32'h5a5a5a5a, 32'ha5a5a5a5, 6, 32'hdeadbeef,
                      16'h1234),
               0, 0, 0, 32'h0, 0, 8'h00, 8'h00, 0, 0),
         known(op_row(hga_pkg::FUNC_READ, 0, 0, 0, 0, 16'd0),
               0, 0, 0, 32'h0, 0, 8'h00, 8'h00, 0, 0),
         // zero width or height drops every hit
         csr_row(9'd0, 9'd511),
         known(op_row(hga_pkg::FUNC_ADD, 0, 0, 1, 32'hffffffff, 0),
               0, 0, 0, 32'h0, 0, 8'h00, 8'h00, 0, 0),
         csr_row(9'd511, 9'd0),
         known(op_row(hga_pkg::FUNC_ADD, 0, 0, 1, 32'hffffffff, 0),
               0, 0, 0, 32'h0, 0, 8'h00, 8'h00, 0, 0),
         // single-cell grid
         csr_row(9'd1, 9'd1),
         known(op_row(hga_pkg::FUNC_ADD, 1, 0, 2, 32'hffffffff, 0),
               0, 0, 0, 32'h0, 0, 8'h00, 8'h00, 0, 0),
         known(op_row(hga_pkg::FUNC_ADD, 0, 1, 2, 32'hffffffff, 0),
               0, 0, 0, 32'h0, 0, 8'h00, 8'h00, 0, 0),
         known(op_row(hga_pkg::FUNC_ADD, 0, 0, 6, 32'haabbccdd, 0),
               1, 1, 1, 32'h555d666e, 6, 8'h00, 8'h00, 1, 0),
         // registers beyond the grid size
         csr_row(9'd300, 9'd257),
         op_row(hga_pkg::FUNC_ADD, 255, 255, 3, 32'h0f0f0f0f, 0),
         op_row(hga_pkg::FUNC_ADD, 256, 0, 3, 32'h0f0f0f0f, 0),
         op_row(hga_pkg::FUNC_READ, 0, 0, 0, 0, 16'd1)
      };

      // reset
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == ROW_CSR) begin
            wait_until_idle();
            configure_grid(directed_plan[i].width_val, directed_plan[i].height_val);
         end else begin
            issue_request(directed_plan[i].op, directed_plan[i].kind == ROW_KNOWN,
                          directed_plan[i].answer);
         end
      end

      // hammer one cell, back to back with no stalls
      wait_until_idle();
      configure_grid(9'd256, 9'd256);
      quiet = 1'b1;
      sat_x = $urandom_range(255);
      sat_y = $urandom_range(255);
      repeat (HAMMER_HITS) begin
         op = random_request();
         op.func = hga_pkg::FUNC_ADD;
         op.hit_x = {1'($urandom), 31'(sat_x)};
         op.hit_y = {1'($urandom), 31'(sat_y)};
         issue_request(op, 1'b0, '0);
      end
      repeat (16) begin
         op = random_request();
         op.func = hga_pkg::FUNC_READ;
         op.read_index = 16'($urandom_range(shadow_list_len - 1));
         issue_request(op, 1'b0, '0);
      end
      quiet = 1'b0;

      // random phases under different grid settings
      for (int phase = 0; phase < 6; phase++) begin
         wait_until_idle();
         unique case (phase)
            0: configure_grid(9'd4, 9'd3);
            1: configure_grid(9'd256, 9'd256);
            2: configure_grid(9'($urandom_range(511)), 9'($urandom_range(511)));
            3: configure_grid(9'd1, 9'd256);
            4: configure_grid(9'd256, 9'd1);
            default: configure_grid(9'($urandom_range(1, 16)), 9'($urandom_range(1, 16)));
         endcase
         if (phase == 1 || phase == 4) begin
            op = random_request();
            op.func = hga_pkg::FUNC_CLEAR;
            issue_request(op, 1'b0, '0);
         end
         repeat (PHASE_ITEMS) issue_request(random_request(), 1'b0, '0);
      end

      // drain and let the pipeline settle
      wait_until_idle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("hit_grid_accumulator_top test passed");
      else
         $display("hit_grid_accumulator_top test failed");
      $finish;
   end

endmodule

/* sim.f */
design/hga_pkg.sv
design/hit_grid_accumulator_top.sv
design/hga_checker.sv
tb/testbench.sv
